// File: hw/rtl/irkfe_pkg.sv
`default_nettype none

package irkfe_pkg;

	localparam int unsigned DATA_BITS_DEF = 20;
	localparam int unsigned ADDR_W        = 5;
	localparam int unsigned APB_DATA_W    = 32;

	localparam logic [3:0]  HEADER_RST      = 4'h4;
	localparam logic [15:0] LEADER_MARK_RST  = 16'd9000;
	localparam logic [15:0] LEADER_SPACE_RST = 16'd4500;
	localparam logic [15:0] ONE_MARK_RST     = 16'd1200;
	localparam logic [15:0] ONE_SPACE_RST    = 16'd400;
	localparam logic [15:0] ZERO_MARK_RST    = 16'd400;
	localparam logic [15:0] ZERO_SPACE_RST   = 16'd400;

	typedef enum logic [2:0] {
		REG_HEADER       = 3'd0,
		REG_LEADER_MARK  = 3'd1,
		REG_LEADER_SPACE = 3'd2,
		REG_ONE_MARK     = 3'd3,
		REG_ONE_SPACE    = 3'd4,
		REG_ZERO_MARK    = 3'd5,
		REG_ZERO_SPACE   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [6:0] scan_code;
		logic [7:0] qualifier_mask;
	} req_t;

	typedef struct packed {
		logic [15:0] mark_us;
		logic [15:0] off_us;
		logic        is_last;
	} pair_t;

endpackage

`default_nettype wire

// File: hw/rtl/ir_keyboard_frame_encoder.sv
// channel | dir | handshake              | payload
// req     | in  | req_valid / req_stall   | irkfe_pkg::req_t  (scan_code, qualifier_mask)
// pair    | out | pair_valid / pair_stall | irkfe_pkg::pair_t (mark_us, off_us, is_last)
// cfg     | in  | APB psel/penable, pready tied high
//
// Each request yields 1 + 2*DATA_BITS pairs (41 at default), one per cycle unless
// pair_stall holds; a new request waits for the frame shift register to drain.
// The next request is taken in the cycle the last pair of the current frame is issued.
// Output stalls hold the pair register and freeze the frame shifter.
// arst_n clears control state and loads the register defaults.
`default_nettype none

module ir_keyboard_frame_encoder #(
	parameter int unsigned DATA_BITS = irkfe_pkg::DATA_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire irkfe_pkg::req_t                   req,
	output logic                                   pair_valid,
	input  wire logic                              pair_stall,
	output irkfe_pkg::pair_t                       pair,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [irkfe_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [irkfe_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [irkfe_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                   pready
);

	localparam int unsigned FRAME_W = 2 * DATA_BITS;
	localparam int unsigned CNT_W   = $clog2(FRAME_W + 1);

	logic [3:0]  header_q;
	logic [15:0] leader_mark_q;
	logic [15:0] leader_space_q;
	logic [15:0] one_mark_q;
	logic [15:0] one_space_q;
	logic [15:0] zero_mark_q;
	logic [15:0] zero_space_q;

	logic               busy_q;
	logic               lead_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FRAME_W-1:0] frame_q;
	logic               pair_valid_q;
	irkfe_pkg::pair_t   pair_q;

	logic               cfg_wr;
	logic               adv;
	logic               gen;
	logic               last_bit;
	logic               req_acc;
	logic [7:0]         scan_inc;
	logic [7:0]         keycode;
	logic [31:0]        word32;
	logic [DATA_BITS-1:0] data_w;
	irkfe_pkg::pair_t   pair_d;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q       <= irkfe_pkg::HEADER_RST;
			leader_mark_q  <= irkfe_pkg::LEADER_MARK_RST;
			leader_space_q <= irkfe_pkg::LEADER_SPACE_RST;
			one_mark_q     <= irkfe_pkg::ONE_MARK_RST;
			one_space_q    <= irkfe_pkg::ONE_SPACE_RST;
			zero_mark_q    <= irkfe_pkg::ZERO_MARK_RST;
			zero_space_q   <= irkfe_pkg::ZERO_SPACE_RST;
		end else if (cfg_wr) begin
			case (irkfe_pkg::reg_idx_t'(paddr[4:2]))
				irkfe_pkg::REG_HEADER:       header_q       <= pwdata[3:0];
				irkfe_pkg::REG_LEADER_MARK:  leader_mark_q  <= pwdata[15:0];
				irkfe_pkg::REG_LEADER_SPACE: leader_space_q <= pwdata[15:0];
				irkfe_pkg::REG_ONE_MARK:     one_mark_q     <= pwdata[15:0];
				irkfe_pkg::REG_ONE_SPACE:    one_space_q    <= pwdata[15:0];
				irkfe_pkg::REG_ZERO_MARK:    zero_mark_q    <= pwdata[15:0];
				irkfe_pkg::REG_ZERO_SPACE:   zero_space_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (irkfe_pkg::reg_idx_t'(paddr[4:2]))
			irkfe_pkg::REG_HEADER:       prdata = {28'd0, header_q};
			irkfe_pkg::REG_LEADER_MARK:  prdata = {16'd0, leader_mark_q};
			irkfe_pkg::REG_LEADER_SPACE: prdata = {16'd0, leader_space_q};
			irkfe_pkg::REG_ONE_MARK:     prdata = {16'd0, one_mark_q};
			irkfe_pkg::REG_ONE_SPACE:    prdata = {16'd0, one_space_q};
			irkfe_pkg::REG_ZERO_MARK:    prdata = {16'd0, zero_mark_q};
			irkfe_pkg::REG_ZERO_SPACE:   prdata = {16'd0, zero_space_q};
			default:                     prdata = '0;
		endcase
	end

	// keycode: bit-reversed (scan + 1), bit 0 cleared
	assign scan_inc = {1'b0, req.scan_code} + 8'd1;
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			keycode[i] = scan_inc[7-i];
		end
		keycode[0] = 1'b0;
	end

	assign word32 = {12'd0, header_q, req.qualifier_mask, keycode};
	assign data_w = word32[DATA_BITS-1:0];

	// handshake
	assign adv      = !pair_valid_q || !pair_stall;
	assign gen      = busy_q && adv;
	assign last_bit = !lead_q && (cnt_q == CNT_W'(1));
	assign req_stall = busy_q && !(gen && last_bit);
	assign req_acc  = req_valid && !req_stall;

	always_comb begin
		if (lead_q) begin
			pair_d.mark_us = leader_mark_q;
			pair_d.off_us  = leader_space_q;
		end else if (frame_q[FRAME_W-1]) begin
			pair_d.mark_us = one_mark_q;
			pair_d.off_us  = one_space_q;
		end else begin
			pair_d.mark_us = zero_mark_q;
			pair_d.off_us  = zero_space_q;
		end
		pair_d.is_last = last_bit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			lead_q       <= 1'b0;
			cnt_q        <= '0;
			pair_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				pair_valid_q <= busy_q;
			end
			if (req_acc) begin
				busy_q <= 1'b1;
				lead_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAME_W);
			end else if (gen) begin
				lead_q <= 1'b0;
				if (last_bit) begin
					busy_q <= 1'b0;
				end
				if (!lead_q) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			frame_q <= {data_w, ~data_w};
		end else if (gen && !lead_q) begin
			frame_q <= {frame_q[FRAME_W-2:0], 1'b0};
		end
		if (gen) begin
			pair_q <= pair_d;
		end
	end

	assign pair_valid = pair_valid_q;
	assign pair       = pair_q;

endmodule

`default_nettype wire

// File: hw/rtl/irkfe_checker.sv
`default_nettype none

module irkfe_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_stall,
	input wire logic             pair_valid,
	input wire logic             pair_stall,
	input wire irkfe_pkg::pair_t pair
);

	// a held pair does not change
	a_pair_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && pair_stall |=> pair_valid && $stable(pair))
		else $error("pair changed while stalled");

	// a new frame holds off the next request in the cycle after it is taken
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while frame in progress");

	// pairs of one frame come without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && !pair_stall && !pair.is_last |=> pair_valid)
		else $error("gap inside frame");

endmodule

bind ir_keyboard_frame_encoder irkfe_checker u_irkfe_checker (.*);

`default_nettype wire
